// ===== design/ckmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ckmc_pkg: shared types and constants
// Queue word layout, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package ckmc_pkg;

  localparam int unsigned CntW   = 21;
  localparam int unsigned SumW   = 37;
  localparam int unsigned CsumW  = 29;
  localparam int unsigned M2W    = 18;
  localparam int unsigned MagW   = 17;
  localparam int unsigned SqInW  = 34;
  localparam int unsigned SqOutW = 17;
  localparam int unsigned DvNW   = 37;
  localparam int unsigned DvDW   = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 21;

  localparam logic [CntW-1:0] CntMax   = {CntW{1'b1}};
  localparam logic [15:0]     OneQ15   = 16'd32768;
  localparam logic [MagW-1:0] MagWin   = 17'd49152;
  localparam logic [MagW-1:0] RefMagRst = 17'd64101;
  localparam logic [15:0]     RefRedRst = 16'd25153;
  localparam logic [15:0]     RefGrnRst = 16'd12605;
  localparam logic [15:0]     RefBluRst = 16'd16797;

  localparam logic [CfgIdxW-1:0] RegSimThr = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinCnt = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd3;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic [15:0]      pos_z;
    logic             point_valid;
    logic             last;
    logic             recal;
    logic             center;
    logic             black;
    logic [M2W-1:0]   m2;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_DIV, ST_DSQ, ST_DIST, ST_ACC, ST_CEN,
    ST_RDIV, ST_RSQ, ST_RMAG, ST_RUNIT, ST_OUT
  } state_e;

endpackage

// ===== design/color_key_mask_centroid.sv =====
// ----------------------------------------------------------------------------
// color_key_mask_centroid: color key mask with frame centroid
// Masks pixels near a unit reference color, sums matched 3D points and
// the central window color, reports the frame summary and recalibrates.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+---------------------------
//  pixel in | input     | in_valid_i / in_stall_o  | rgb, point, col, row, flags
//  result   | output    | out_valid_o / out_stall_i| mask and frame summary
//  config   | input     | cfg_valid_i / cfg_ready_o| register index and data
//
// In the back sequencer a pixel runs two square roots and three divides on the
// shared units, plus the squares and control states; a black pixel skips them.
// A final pixel adds up to three centroid divides, and a recalibration three
// more divides, a root and three unit divides. Reset loads the default reference
// and clears all sums. A two-word queue accepts pixels while the back works;
// a waiting result word holds in the output register until out_stall_i drops.
module color_key_mask_centroid #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  input  logic signed [15:0]              pos_x_i,
  input  logic signed [15:0]              pos_y_i,
  input  logic signed [15:0]              pos_z_i,
  input  logic                            point_valid_i,
  input  logic [9:0]                      col_i,
  input  logic [9:0]                      row_i,
  input  logic                            last_in_frame_i,
  input  logic                            recalibrate_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      mask_o,
  output logic                            frame_done_o,
  output logic [20:0]                     match_count_o,
  output logic signed [15:0]              centroid_x_o,
  output logic signed [15:0]              centroid_y_o,
  output logic signed [15:0]              centroid_z_o,
  output logic                            beacon_present_o,
  output logic [20:0]                     center_pixels_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ckmc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ckmc_pkg::CfgDatW-1:0]    cfg_data_i
);
  logic [7:0]  sim_thr_q;
  logic [20:0] min_cnt_q;
  logic [10:0] width_q, height_q;
  logic        empty, pop;
  ckmc_pkg::item_t head;
  logic [15:0] cx, cy, cz;

  // always ready: a write takes effect in the next cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_thr_q <= 8'd210;
      min_cnt_q <= 21'd4000;
      width_q   <= 11'd640;
      height_q  <= 11'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ckmc_pkg::RegSimThr: sim_thr_q <= cfg_data_i[7:0];
        ckmc_pkg::RegMinCnt: min_cnt_q <= cfg_data_i;
        ckmc_pkg::RegWidth:  width_q   <= cfg_data_i[10:0];
        ckmc_pkg::RegHeight: height_q  <= cfg_data_i[10:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // front: classify and queue pixels
  ckmc_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .red_i, .green_i, .blue_i,
    .pos_x_i(pos_x_i), .pos_y_i(pos_y_i), .pos_z_i(pos_z_i),
    .point_valid_i, .col_i, .row_i, .last_in_frame_i, .recalibrate_i,
    .frame_width_i(width_q), .frame_height_i(height_q),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  // back: compute similarity, accumulate, summarize
  ckmc_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .sim_threshold_i(sim_thr_q), .min_count_i(min_cnt_q),
    .out_valid_o, .out_stall_i, .mask_o, .frame_done_o, .match_count_o,
    .centroid_x_o(cx), .centroid_y_o(cy), .centroid_z_o(cz),
    .beacon_present_o, .center_pixels_o
  );

  assign centroid_x_o = cx;
  assign centroid_y_o = cy;
  assign centroid_z_o = cz;

  a_mask_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mask_o == 8'd0 || mask_o == 8'd255))
    else $error("mask is neither 0 nor 255");
  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> match_count_o == '0 && center_pixels_o == '0
    && !beacon_present_o) else $error("summary set on a non-final pixel");
  a_empty_centroid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_count_o == '0 |-> centroid_x_o == '0 && centroid_y_o == '0
    && centroid_z_o == '0) else $error("centroid set with no matches");
endmodule

// ===== design/ckmc_div.sv =====
// ----------------------------------------------------------------------------
// ckmc_div: restoring unsigned divider
// One quotient bit per cycle; done pulses with quotient held.
// ----------------------------------------------------------------------------
module ckmc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ckmc_pkg::DvNW-1:0]     dividend_i,
  input  logic [ckmc_pkg::DvDW-1:0]     divisor_i,
  output logic                          done_o,
  output logic [ckmc_pkg::DvNW-1:0]     quotient_o
);
  localparam int unsigned N = ckmc_pkg::DvNW;
  localparam int unsigned D = ckmc_pkg::DvDW;

  logic [N-1:0] quo_q;
  logic [D-1:0] rem_q, div_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [D:0]   tmp, diff;
  logic         take;

  assign tmp  = {rem_q, quo_q[N-1]};
  assign diff = tmp - {1'b0, div_q};
  assign take = (tmp >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[D-1:0] : tmp[D-1:0];
      quo_q <= {quo_q[N-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ===== design/ckmc_sqrt.sv =====
// ----------------------------------------------------------------------------
// ckmc_sqrt: digit-by-digit integer square root
// Two operand bits per cycle, floor result; done pulses with root held.
// ----------------------------------------------------------------------------
module ckmc_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ckmc_pkg::SqInW-1:0]    operand_i,
  output logic                          done_o,
  output logic [ckmc_pkg::SqOutW-1:0]   root_o
);
  localparam int unsigned W = ckmc_pkg::SqInW;
  localparam int unsigned R = ckmc_pkg::SqOutW;

  logic [W-1:0] op_q;
  logic [R+2:0] rem_q, rem_s, trial;
  logic [R-1:0] root_q;
  logic [4:0]   cnt_q;
  logic         busy_q, done_q;
  logic         take;

  assign rem_s = {rem_q[R:0], op_q[W-1:W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = (rem_s >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(R);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= operand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[W-3:0], 2'b00};
      rem_q  <= take ? (rem_s - trial) : rem_s;
      root_q <= {root_q[R-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== design/ckmc_front.sv =====
// ----------------------------------------------------------------------------
// ckmc_front: pixel intake and classification
// Tags window membership and black pixels, forms r2+g2+b2, queues the word.
// ----------------------------------------------------------------------------
module ckmc_front #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [15:0]          pos_x_i,
  input  logic [15:0]          pos_y_i,
  input  logic [15:0]          pos_z_i,
  input  logic                 point_valid_i,
  input  logic [9:0]           col_i,
  input  logic [9:0]           row_i,
  input  logic                 last_in_frame_i,
  input  logic                 recalibrate_i,
  input  logic [10:0]          frame_width_i,
  input  logic [10:0]          frame_height_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ckmc_pkg::item_t      head_o
);
  localparam int unsigned CW = $clog2(MAX_COLS + 1) + 4;
  localparam int unsigned RW = $clog2(MAX_ROWS + 1) + 4;

  ckmc_pkg::item_t q_mem [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic [CW-1:0]   w, c_lo, c_hi;
  logic [RW-1:0]   h, r_lo, r_hi;
  ckmc_pkg::item_t word;

  always_comb begin
    w = (32'(frame_width_i) > MAX_COLS) ? CW'(MAX_COLS) : CW'(frame_width_i);
    h = (32'(frame_height_i) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(frame_height_i);
    c_lo = (w * CW'(7)) >> 4;
    c_hi = (w * CW'(9)) >> 4;
    r_lo = (h * RW'(7)) >> 4;
    r_hi = (h * RW'(9)) >> 4;
    word.red         = red_i;
    word.green       = green_i;
    word.blue        = blue_i;
    word.pos_x       = pos_x_i;
    word.pos_y       = pos_y_i;
    word.pos_z       = pos_z_i;
    word.point_valid = point_valid_i;
    word.last        = last_in_frame_i;
    word.recal       = recalibrate_i;
    word.center      = (CW'(col_i) >= c_lo) && (CW'(col_i) <= c_hi) &&
                       (RW'(row_i) >= r_lo) && (RW'(row_i) <= r_hi);
    word.black       = (red_i == 8'd0) && (green_i == 8'd0) && (blue_i == 8'd0);
    word.m2          = ckmc_pkg::M2W'(16'(red_i) * 16'(red_i)) +
                       ckmc_pkg::M2W'(16'(green_i) * 16'(green_i)) +
                       ckmc_pkg::M2W'(16'(blue_i) * 16'(blue_i));
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign empty_o    = (cnt_q == 2'd0);
  assign head_o     = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= word;
  end
endmodule

// ===== design/ckmc_back.sv =====
// ----------------------------------------------------------------------------
// ckmc_back: per-pixel sequencer and frame accumulators
// Drives the shared divider and square root over each queued word.
// ----------------------------------------------------------------------------
module ckmc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  ckmc_pkg::item_t             head_i,
  output logic                        pop_o,
  input  logic [7:0]                  sim_threshold_i,
  input  logic [ckmc_pkg::CntW-1:0]   min_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  mask_o,
  output logic                        frame_done_o,
  output logic [ckmc_pkg::CntW-1:0]   match_count_o,
  output logic [15:0]                 centroid_x_o,
  output logic [15:0]                 centroid_y_o,
  output logic [15:0]                 centroid_z_o,
  output logic                        beacon_present_o,
  output logic [ckmc_pkg::CntW-1:0]   center_pixels_o
);
  localparam int unsigned CntW  = ckmc_pkg::CntW;
  localparam int unsigned SumW  = ckmc_pkg::SumW;
  localparam int unsigned CsumW = ckmc_pkg::CsumW;

  ckmc_pkg::state_e state_q, state_d;
  ckmc_pkg::item_t  item_q;
  logic [1:0]       idx_q, idx_d;
  logic             wait_q, wait_d;

  logic [ckmc_pkg::MagW-1:0] mag_q, ref_mag_q;
  logic [15:0]               ref_q [3];
  logic [15:0]               n_q [3];
  logic [15:0]               a_q [3];
  logic [15:0]               cent_q [3];
  logic [ckmc_pkg::SqInW-1:0] acc_q;
  logic [7:0]                sim_q;

  logic [CntW-1:0]           match_q, center_q;
  logic signed [SumW-1:0]    sum_q [3];
  logic [CsumW-1:0]          csum_q [3];

  logic div_start, div_done, sq_start, sq_done;
  logic [ckmc_pkg::DvNW-1:0]   div_n, div_quo;
  logic [ckmc_pkg::DvDW-1:0]   div_d;
  logic [ckmc_pkg::SqInW-1:0]  sq_in;
  logic [ckmc_pkg::SqOutW-1:0] sq_root;

  logic [15:0] mul_a;
  logic [31:0] mul_p;
  logic [7:0]  comp;
  logic [SumW-1:0] sum_mag;
  logic        sum_neg, out_free, last_comp;
  logic [ckmc_pkg::DvNW-1:0] q_clamp;
  logic [15:0] sub_x;
  logic [23:0] sim_prod;
  logic [ckmc_pkg::MagW-1:0] mag_diff;
  logic        mask_hit, match_now, center_now;

  ckmc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n),
    .divisor_i(div_d), .done_o(div_done), .quotient_o(div_quo)
  );

  ckmc_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .operand_i(sq_in),
    .done_o(sq_done), .root_o(sq_root)
  );

  always_comb begin
    unique case (idx_q)
      2'd0:    comp = item_q.red;
      2'd1:    comp = item_q.green;
      default: comp = item_q.blue;
    endcase
  end

  assign last_comp = (idx_q == 2'd2);
  assign sum_neg   = sum_q[idx_q][SumW-1];
  assign sum_mag   = sum_neg ? SumW'(-sum_q[idx_q]) : SumW'(sum_q[idx_q]);
  assign q_clamp   = (div_quo > ckmc_pkg::DvNW'(ckmc_pkg::OneQ15)) ?
                     ckmc_pkg::DvNW'(ckmc_pkg::OneQ15) : div_quo;
  assign out_free  = !out_valid_o || !out_stall_i;

  // shared squarer for the distance and the recalibration magnitude
  always_comb begin
    if (state_q == ckmc_pkg::ST_RSQ) begin
      mul_a = a_q[idx_q];
    end else begin
      mul_a = (n_q[idx_q] > ref_q[idx_q]) ? (n_q[idx_q] - ref_q[idx_q]) :
                                            (ref_q[idx_q] - n_q[idx_q]);
    end
    mul_p = 32'(mul_a) * 32'(mul_a);
  end

  always_comb begin
    mag_diff = (mag_q > ref_mag_q) ? (mag_q - ref_mag_q) : (ref_mag_q - mag_q);
    sub_x    = ckmc_pkg::OneQ15 - sq_root[15:0];
    sim_prod = {sub_x, 8'd0} - 24'(sub_x);
    mask_hit   = ((sim_q >= sim_threshold_i) ? 8'd255 : 8'd0) >= sim_threshold_i;
    match_now  = mask_hit && item_q.point_valid && (match_q != ckmc_pkg::CntMax);
    center_now = item_q.center && (center_q != ckmc_pkg::CntMax);
  end

  // next state and unit controls
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    wait_d    = wait_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    div_n     = '0;
    div_d     = '0;
    sq_in     = '0;
    unique case (state_q)
      ckmc_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = head_i.black ? ckmc_pkg::ST_ACC : ckmc_pkg::ST_MAG;
        end
      end
      ckmc_pkg::ST_MAG: begin
        sq_in = {item_q.m2, 16'd0};
        if (!wait_q) begin
          sq_start = 1'b1;
          wait_d   = 1'b1;
        end else if (sq_done) begin
          wait_d  = 1'b0;
          idx_d   = 2'd0;
          state_d = ckmc_pkg::ST_DIV;
        end
      end
      ckmc_pkg::ST_DIV, ckmc_pkg::ST_RDIV, ckmc_pkg::ST_RUNIT: begin
        if (state_q == ckmc_pkg::ST_DIV) begin
          div_n = ckmc_pkg::DvNW'({comp, 23'd0});
          div_d = ckmc_pkg::DvDW'(mag_q);
        end else if (state_q == ckmc_pkg::ST_RDIV) begin
          div_n = ckmc_pkg::DvNW'({csum_q[idx_q], 8'd0});
          div_d = center_q;
        end else begin
          div_n = ckmc_pkg::DvNW'({a_q[idx_q], 15'd0});
          div_d = ckmc_pkg::DvDW'(ref_mag_q);
        end
        if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d = 1'b0;
          idx_d  = last_comp ? 2'd0 : idx_q + 2'd1;
          if (last_comp) begin
            priority case (state_q)
              ckmc_pkg::ST_DIV:  state_d = ckmc_pkg::ST_DSQ;
              ckmc_pkg::ST_RDIV: state_d = ckmc_pkg::ST_RSQ;
              default:           state_d = ckmc_pkg::ST_OUT;
            endcase
          end
        end
      end
      ckmc_pkg::ST_DSQ, ckmc_pkg::ST_RSQ: begin
        idx_d = last_comp ? 2'd0 : idx_q + 2'd1;
        if (last_comp) begin
          state_d = (state_q == ckmc_pkg::ST_DSQ) ? ckmc_pkg::ST_DIST : ckmc_pkg::ST_RMAG;
        end
      end
      ckmc_pkg::ST_DIST, ckmc_pkg::ST_RMAG: begin
        sq_in = acc_q;
        if (!wait_q) begin
          sq_start = 1'b1;
          wait_d   = 1'b1;
        end else if (sq_done) begin
          wait_d = 1'b0;
          if (state_q == ckmc_pkg::ST_DIST) begin
            state_d = ckmc_pkg::ST_ACC;
          end else begin
            state_d = (sq_root == '0) ? ckmc_pkg::ST_OUT : ckmc_pkg::ST_RUNIT;
          end
        end
      end
      ckmc_pkg::ST_ACC: begin
        idx_d   = 2'd0;
        state_d = item_q.last ? ckmc_pkg::ST_CEN : ckmc_pkg::ST_OUT;
      end
      ckmc_pkg::ST_CEN: begin
        div_n = ckmc_pkg::DvNW'(sum_mag);
        div_d = match_q;
        if (match_q == '0) begin
          idx_d = last_comp ? 2'd0 : idx_q + 2'd1;
        end else if (!wait_q) begin
          div_start = 1'b1;
          wait_d    = 1'b1;
        end else if (div_done) begin
          wait_d = 1'b0;
          idx_d  = last_comp ? 2'd0 : idx_q + 2'd1;
        end
        if (last_comp && ((match_q == '0) || (wait_q && div_done))) begin
          state_d = (item_q.recal && (center_q != '0)) ? ckmc_pkg::ST_RDIV :
                                                         ckmc_pkg::ST_OUT;
        end
      end
      ckmc_pkg::ST_OUT: begin
        if (out_free) state_d = ckmc_pkg::ST_IDLE;
      end
      default: state_d = ckmc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ckmc_pkg::ST_IDLE;
      idx_q     <= 2'd0;
      wait_q    <= 1'b0;
      out_valid_o <= 1'b0;
      ref_mag_q <= ckmc_pkg::RefMagRst;
      ref_q[0]  <= ckmc_pkg::RefRedRst;
      ref_q[1]  <= ckmc_pkg::RefGrnRst;
      ref_q[2]  <= ckmc_pkg::RefBluRst;
      match_q   <= '0;
      center_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        csum_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      wait_q  <= wait_d;
      if (state_q == ckmc_pkg::ST_OUT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == ckmc_pkg::ST_RMAG && sq_done && sq_root != '0) begin
        ref_mag_q <= sq_root;
      end
      if (state_q == ckmc_pkg::ST_RUNIT && div_done) begin
        ref_q[idx_q] <= q_clamp[15:0];
      end
      if (state_q == ckmc_pkg::ST_ACC) begin
        if (match_now) begin
          match_q  <= match_q + CntW'(1);
          sum_q[0] <= sum_q[0] + SumW'(signed'(item_q.pos_x));
          sum_q[1] <= sum_q[1] + SumW'(signed'(item_q.pos_y));
          sum_q[2] <= sum_q[2] + SumW'(signed'(item_q.pos_z));
        end
        if (center_now) begin
          center_q  <= center_q + CntW'(1);
          csum_q[0] <= csum_q[0] + CsumW'(item_q.red);
          csum_q[1] <= csum_q[1] + CsumW'(item_q.green);
          csum_q[2] <= csum_q[2] + CsumW'(item_q.blue);
        end
      end
      if (state_q == ckmc_pkg::ST_OUT && out_free) begin
        if (item_q.last) begin
          match_q  <= '0;
          center_q <= '0;
          for (int k = 0; k < 3; k++) begin
            sum_q[k]  <= '0;
            csum_q[k] <= '0;
          end
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ckmc_pkg::ST_IDLE: begin
        item_q <= head_i;
        sim_q  <= 8'd0;
      end
      ckmc_pkg::ST_MAG: if (sq_done) mag_q <= sq_root;
      ckmc_pkg::ST_DIV: if (div_done) n_q[idx_q] <= q_clamp[15:0];
      ckmc_pkg::ST_DSQ: begin
        acc_q <= ((idx_q == 2'd0) ? '0 : acc_q) + ckmc_pkg::SqInW'(mul_p);
      end
      ckmc_pkg::ST_RSQ: begin
        acc_q <= ((idx_q == 2'd0) ? '0 : acc_q) + ckmc_pkg::SqInW'(mul_p);
      end
      ckmc_pkg::ST_DIST: begin
        if (sq_done) begin
          if (sq_root >= ckmc_pkg::SqOutW'(ckmc_pkg::OneQ15) ||
              mag_diff > ckmc_pkg::MagWin) begin
            sim_q <= 8'd0;
          end else begin
            sim_q <= sim_prod[22:15];
          end
        end
      end
      ckmc_pkg::ST_CEN: begin
        if (match_q == '0) begin
          cent_q[idx_q] <= 16'd0;
        end else if (div_done) begin
          cent_q[idx_q] <= sum_neg ? 16'(-div_quo[15:0]) : div_quo[15:0];
        end
      end
      ckmc_pkg::ST_RDIV: if (div_done) a_q[idx_q] <= div_quo[15:0];
      ckmc_pkg::ST_OUT: begin
        if (out_free) begin
          mask_o           <= (sim_q >= sim_threshold_i) ? 8'd255 : 8'd0;
          frame_done_o     <= item_q.last;
          match_count_o    <= item_q.last ? match_q : '0;
          centroid_x_o     <= item_q.last ? cent_q[0] : 16'd0;
          centroid_y_o     <= item_q.last ? cent_q[1] : 16'd0;
          centroid_z_o     <= item_q.last ? cent_q[2] : 16'd0;
          beacon_present_o <= item_q.last && (match_q >= min_count_i);
          center_pixels_o  <= item_q.last ? center_q : '0;
        end
      end
      default: ;
    endcase
  end

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && sq_start)) else $error("divider and root started together");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ckmc_pkg::ST_IDLE) && !empty_i)
    else $error("queue popped outside idle");
  a_no_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ckmc_pkg::ST_IDLE |-> !wait_q) else $error("unit wait left set");
endmodule
